// ----- hw/rtl/conv2d_replicate_border_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the replicated-border convolution core
// Shared by the checker; one assertion per use.
// ----------------------------------------------------------------------------
`ifndef CONV2D_REPLICATE_BORDER_CORE_MACROS_SVH
`define CONV2D_REPLICATE_BORDER_CORE_MACROS_SVH

// Next-cycle implication, masked while reset is asserted
`define CDRB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication that also covers reset
`define CDRB_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: reset check failed");

`endif

// ----- hw/rtl/cdrb_pkg.sv -----
// ----------------------------------------------------------------------------
// cdrb_pkg
// Types and fixed constants of the replicated-border convolution core.
// ----------------------------------------------------------------------------
package cdrb_pkg;

  localparam int KMAX         = 5;
  localparam int COL_BITS     = 12;
  localparam int DIM_BITS     = 13;
  localparam int SLOT_BITS    = 3;
  localparam int DIFF_BITS    = 16;
  localparam int FIELD_STRIDE = 12;
  localparam int FRAC_BITS    = 8;
  localparam int PIXEL_MAX    = 255;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int KREG_BITS    = 60;
  localparam int PROD_BITS    = 20;
  localparam int ROW_BITS     = 23;
  localparam int ACC_BITS     = 26;

  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_KERNEL_A     = 3'd2,
    CFG_KERNEL_B     = 3'd3,
    CFG_KERNEL_C     = 3'd4,
    CFG_KERNEL_D     = 3'd5,
    CFG_KERNEL_E     = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] pixel_in;
    logic       drain;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic                                 wr_en;
    logic [SLOT_BITS-1:0]                 wr_slot;
    logic [COL_BITS-1:0]                  wr_col;
    logic [7:0]                           wr_pix;
    logic                                 emit;
    logic                                 last;
    logic [KMAX-1:0][COL_BITS-1:0]        rd_col;
    logic [KMAX-1:0][SLOT_BITS-1:0]       rd_slot;
  } q_entry_t;

endpackage

// ----- hw/rtl/cdrb_front.sv -----
// ----------------------------------------------------------------------------
// cdrb_front
// Tracks input and output raster positions, decides per item whether a pixel
// is stored and whether an output is due, and builds the tap addresses.
// ----------------------------------------------------------------------------
module cdrb_front #(
  parameter int WIN_SIZE  = 3,
  parameter int MAX_WIDTH = 2048
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  cdrb_pkg::in_item_t        item,
  input  logic [11:0]               image_width,
  input  logic [12:0]               image_height,
  output cdrb_pkg::q_entry_t        entry
);

  localparam int CTR   = WIN_SIZE / 2;
  localparam int SLOTS = WIN_SIZE + 1;
  localparam int DB    = cdrb_pkg::DIM_BITS;
  localparam int CB    = cdrb_pkg::COL_BITS;
  localparam int SB    = cdrb_pkg::SLOT_BITS;
  localparam int FB    = cdrb_pkg::DIFF_BITS;

  logic [CB-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [DB-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [SB-1:0] in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic [FB-1:0] diff_r, diff_nxt;

  logic [DB-1:0] w_eff, h_eff;
  logic [FB-1:0] delay, diff_inc;
  logic          is_pix, flush, emit, last, col_wrap, out_wrap;

  always_comb begin
    if (image_width == 12'd0) begin
      w_eff = DB'(1);
    end else if ({1'b0, image_width} > DB'(MAX_WIDTH)) begin
      w_eff = DB'(MAX_WIDTH);
    end else begin
      w_eff = {1'b0, image_width};
    end
    if (image_height == 13'd0) begin
      h_eff = DB'(1);
    end else if (image_height > DB'(cdrb_pkg::HEIGHT_LIMIT)) begin
      h_eff = DB'(cdrb_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = image_height;
    end
  end

  assign delay    = FB'(w_eff) * FB'(CTR) + FB'(CTR);
  assign is_pix   = !item.drain && (in_row_r < h_eff);
  assign flush    = !is_pix && (in_row_r >= h_eff);
  assign diff_inc = diff_r + FB'(is_pix);
  assign emit     = (is_pix && (diff_inc > delay)) || flush;
  assign col_wrap = (DB'(in_col_r) + DB'(1)) >= w_eff;
  assign out_wrap = (DB'(out_col_r) + DB'(1)) >= w_eff;
  assign last     = (out_row_r > h_eff - DB'(1)) ||
                    ((out_row_r == h_eff - DB'(1)) && out_wrap);

  always_comb begin
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    in_slot_nxt  = in_slot_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_slot_nxt = out_slot_r;
    diff_nxt     = diff_r;
    if (accept) begin
      if (is_pix) begin
        if (col_wrap) begin
          in_col_nxt  = '0;
          in_row_nxt  = in_row_r + DB'(1);
          in_slot_nxt = (in_slot_r == SB'(SLOTS - 1)) ? '0 : in_slot_r + SB'(1);
        end else begin
          in_col_nxt = in_col_r + CB'(1);
        end
      end
      diff_nxt = diff_inc;
      if (emit) begin
        if (last) begin
          // frame done: restart all positions
          in_col_nxt   = '0;
          in_row_nxt   = '0;
          in_slot_nxt  = '0;
          out_col_nxt  = '0;
          out_row_nxt  = '0;
          out_slot_nxt = '0;
          diff_nxt     = '0;
        end else begin
          diff_nxt = diff_inc - FB'(1);
          if (out_wrap) begin
            out_col_nxt  = '0;
            out_row_nxt  = out_row_r + DB'(1);
            out_slot_nxt = (out_slot_r == SB'(SLOTS - 1)) ? '0 : out_slot_r + SB'(1);
          end else begin
            out_col_nxt = out_col_r + CB'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_slot_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_slot_r <= '0;
      diff_r     <= '0;
    end else begin
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      in_slot_r  <= in_slot_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_slot_r <= out_slot_nxt;
      diff_r     <= diff_nxt;
    end
  end

  // Tap addresses: clamp columns to the row, rows to the frame
  logic signed [14:0] xs, ys, dy, ss;
  always_comb begin
    entry         = '0;
    entry.wr_en   = is_pix;
    entry.wr_slot = in_slot_r;
    entry.wr_col  = in_col_r;
    entry.wr_pix  = item.pixel_in;
    entry.emit    = emit;
    entry.last    = last;
    xs = '0;
    ys = '0;
    dy = '0;
    ss = '0;
    for (int i = 0; i < cdrb_pkg::KMAX; i++) begin
      if (i < WIN_SIZE) begin
        xs = $signed({3'b000, out_col_r}) + 15'(i) - 15'(CTR);
        if (xs < 0) begin
          xs = '0;
        end else if (xs >= $signed({2'b00, w_eff})) begin
          xs = $signed({2'b00, w_eff}) - 15'sd1;
        end
        entry.rd_col[i] = xs[CB-1:0];

        ys = $signed({2'b00, out_row_r}) + 15'(i) - 15'(CTR);
        if (ys < 0) begin
          ys = '0;
        end else if (ys >= $signed({2'b00, h_eff})) begin
          ys = $signed({2'b00, h_eff}) - 15'sd1;
        end
        dy = ys - $signed({2'b00, out_row_r});
        ss = $signed({12'd0, out_slot_r}) + dy;
        if (ss < 0) begin
          ss = ss + 15'(SLOTS);
        end else if (ss >= 15'sd0 + 15'(SLOTS)) begin
          ss = ss - 15'(SLOTS);
        end
        entry.rd_slot[i] = ss[SB-1:0];
      end
    end
  end

endmodule

// ----- hw/rtl/cdrb_queue.sv -----
// ----------------------------------------------------------------------------
// cdrb_queue
// Four-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module cdrb_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cdrb_pkg::q_entry_t  push_entry,
  output logic                full,
  input  logic                pop,
  output cdrb_pkg::q_entry_t  head,
  output logic                empty
);

  localparam int DEPTH = 4;
  localparam int AB    = $clog2(DEPTH);

  cdrb_pkg::q_entry_t store_r [DEPTH];
  logic [AB-1:0]      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AB:0]        cnt_r, cnt_nxt;

  assign full  = (cnt_r == (AB + 1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = store_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + AB'(1) : wp_r;
    rp_nxt  = pop ? rp_r + AB'(1) : rp_r;
    cnt_nxt = cnt_r + (AB + 1)'(push) - (AB + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wp_r] <= push_entry;
    end
  end

endmodule

// ----- hw/rtl/cdrb_back.sv -----
// ----------------------------------------------------------------------------
// cdrb_back
// Writes pixels to the line banks, reads the window, multiplies, sums,
// saturates and holds the result in the output register.
// ----------------------------------------------------------------------------
module cdrb_back #(
  parameter int WIN_SIZE  = 3,
  parameter int MAX_WIDTH = 2048,
  parameter int COEF_BITS = 12
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               q_empty,
  input  cdrb_pkg::q_entry_t                                 q_head,
  output logic                                               q_pop,
  input  logic [cdrb_pkg::KMAX-1:0][cdrb_pkg::KREG_BITS-1:0] kernel,
  output logic                                               out_valid,
  input  logic                                               out_ready,
  output cdrb_pkg::out_item_t                                out_data
);

  localparam int K     = WIN_SIZE;
  localparam int KM    = cdrb_pkg::KMAX;
  localparam int SLOTS = WIN_SIZE + 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int SW    = $clog2(SLOTS);
  localparam int PB    = cdrb_pkg::PROD_BITS;
  localparam int RB    = cdrb_pkg::ROW_BITS;
  localparam int AB    = cdrb_pkg::ACC_BITS;

  logic advance;
  logic out_valid_r;

  assign advance = !out_valid_r || out_ready;
  assign q_pop   = advance && !q_empty;

  // Line banks: one copy per column tap, one bank per stored row
  logic [7:0] bank [K][SLOTS][MAX_WIDTH];
  logic [7:0] rd_r [K][SLOTS];

  logic                                      s0_valid_r, s0_last_r;
  logic [KM-1:0][cdrb_pkg::COL_BITS-1:0]     s0_col_r;
  logic [KM-1:0][cdrb_pkg::SLOT_BITS-1:0]    s0_slot_r, s1_slot_r;
  logic                                      s1_valid_r, s1_last_r;
  logic                                      s2_valid_r, s2_last_r;
  logic                                      s3_valid_r, s3_last_r;
  logic                                      s4_valid_r, s4_last_r;
  logic signed [PB-1:0]                      prod_r [KM][KM];
  logic signed [RB-1:0]                      rsum_r [KM];
  logic signed [AB-1:0]                      total_r;
  cdrb_pkg::out_item_t                       out_data_r;

  always_ff @(posedge clk) begin
    for (int s = 0; s < SLOTS; s++) begin
      if (q_pop && q_head.wr_en && (q_head.wr_slot == cdrb_pkg::SLOT_BITS'(s))) begin
        for (int j = 0; j < K; j++) begin
          bank[j][s][q_head.wr_col[CW-1:0]] <= q_head.wr_pix;
        end
      end
    end
    if (advance) begin
      for (int j = 0; j < K; j++) begin
        for (int s = 0; s < SLOTS; s++) begin
          rd_r[j][s] <= bank[j][s][s0_col_r[j][CW-1:0]];
        end
      end
    end
  end

  // Control flags of the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s0_valid_r  <= q_pop && q_head.emit;
      s1_valid_r  <= s0_valid_r;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  logic [7:0]                 pix;
  logic signed [COEF_BITS-1:0] cf;
  logic signed [PB-1:0]       pe, ce;
  logic signed [PB-1:0]       prod_nxt [KM][KM];
  logic signed [RB-1:0]       rsum_nxt [KM];
  logic signed [AB-1:0]       total_nxt;
  cdrb_pkg::out_item_t        out_nxt;

  always_comb begin
    pix = '0;
    cf  = '0;
    pe  = '0;
    ce  = '0;
    for (int j = 0; j < KM; j++) begin
      for (int k = 0; k < KM; k++) begin
        prod_nxt[j][k] = '0;
        if (j < K && k < K) begin
          pix = rd_r[j][s1_slot_r[k][SW-1:0]];
          cf  = $signed(kernel[j][k*cdrb_pkg::FIELD_STRIDE +: COEF_BITS]);
          pe  = $signed({{(PB - 8){1'b0}}, pix});
          ce  = PB'(cf);
          prod_nxt[j][k] = pe * ce;
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < KM; j++) begin
      rsum_nxt[j] = '0;
      for (int k = 0; k < KM; k++) begin
        rsum_nxt[j] = rsum_nxt[j] + RB'(prod_r[j][k]);
      end
    end
    total_nxt = '0;
    for (int j = 0; j < KM; j++) begin
      total_nxt = total_nxt + AB'(rsum_r[j]);
    end
  end

  // Clip: negative gives zero, drop the fraction, cap at full scale
  always_comb begin
    out_nxt.frame_last = s4_last_r;
    if (total_r < 0) begin
      out_nxt.pixel_out = '0;
    end else if ((total_r >>> cdrb_pkg::FRAC_BITS) > AB'(cdrb_pkg::PIXEL_MAX)) begin
      out_nxt.pixel_out = 8'(cdrb_pkg::PIXEL_MAX);
    end else begin
      out_nxt.pixel_out = total_r[cdrb_pkg::FRAC_BITS +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_last_r  <= q_head.last;
      s0_col_r   <= q_head.rd_col;
      s0_slot_r  <= q_head.rd_slot;
      s1_last_r  <= s0_last_r;
      s1_slot_r  <= s0_slot_r;
      s2_last_r  <= s1_last_r;
      prod_r     <= prod_nxt;
      s3_last_r  <= s2_last_r;
      rsum_r     <= rsum_nxt;
      s4_last_r  <= s3_last_r;
      total_r    <= total_nxt;
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hw/rtl/conv2d_replicate_border_core.sv -----
// ----------------------------------------------------------------------------
// conv2d_replicate_border_core
// Streaming convolution over a centered square window with edge replication.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the result side keeps up.
// Path: an item that causes a result passes the queue, the tap-address
//   register, bank read, multiply, two sum stages and clip to out_valid.
// Outputs start CTR rows plus CTR pixels after the first input of a frame.
// Reset (rst_n low, synchronous) clears positions, queue and stage flags;
//   registers return to 640 x 480 and an all-zero kernel. Line banks are not
//   cleared and need no clearing pass.
module conv2d_replicate_border_core #(
  parameter int WIN_SIZE  = 3,
  parameter int MAX_WIDTH = 2048,
  parameter int COEF_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  cdrb_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output cdrb_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [cdrb_pkg::KREG_BITS-1:0]      cfg_wdata
);

  logic [11:0] image_width_r;
  logic [12:0] image_height_r;
  logic [cdrb_pkg::KMAX-1:0][cdrb_pkg::KREG_BITS-1:0] kernel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= 12'd640;
      image_height_r <= 13'd480;
      kernel_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cdrb_pkg::CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[11:0];
        cdrb_pkg::CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[12:0];
        cdrb_pkg::CFG_KERNEL_A:     kernel_r[0]    <= cfg_wdata;
        cdrb_pkg::CFG_KERNEL_B:     kernel_r[1]    <= cfg_wdata;
        cdrb_pkg::CFG_KERNEL_C:     kernel_r[2]    <= cfg_wdata;
        cdrb_pkg::CFG_KERNEL_D:     kernel_r[3]    <= cfg_wdata;
        cdrb_pkg::CFG_KERNEL_E:     kernel_r[4]    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic               accept, q_full, q_empty, q_pop;
  cdrb_pkg::q_entry_t entry, q_head;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  cdrb_front #(
    .WIN_SIZE  (WIN_SIZE),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .item         (in_data),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .entry        (entry)
  );

  cdrb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_entry (entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  cdrb_back #(
    .WIN_SIZE  (WIN_SIZE),
    .MAX_WIDTH (MAX_WIDTH),
    .COEF_BITS (COEF_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .kernel    (kernel_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/cdrb_checker.sv -----
// ----------------------------------------------------------------------------
// cdrb_checker
// Port-level checks of the convolution core, attached by bind.
// ----------------------------------------------------------------------------
`include "conv2d_replicate_border_core_macros.svh"

module cdrb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input cdrb_pkg::out_item_t out_data
);

  `CDRB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `CDRB_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))
  `CDRB_ASSERT_RST(a_rst_no_out, !rst_n, !out_valid)
  `CDRB_ASSERT_RST(a_rst_ready, !rst_n, in_ready)

endmodule

bind conv2d_replicate_border_core cdrb_checker u_cdrb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- sim/conv2d_replicate_border_core_checker.sv -----
// ----------------------------------------------------------------------------
// Result checker for the replicated-border convolution core
// Watches both channels and the register port, keeps its own line store and
// coefficients, predicts each filtered pixel and compares it in order.
// ----------------------------------------------------------------------------
module conv2d_replicate_border_core_checker #(
  parameter int WIN_SIZE  = 3,
  parameter int MAX_WIDTH = 2048,
  parameter int COEF_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  cdrb_pkg::in_item_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  cdrb_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [cdrb_pkg::KREG_BITS-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             pending_count
);

  localparam int HALF  = WIN_SIZE / 2;
  localparam int SLOTS = WIN_SIZE + 1;

  logic [11:0]                    width_reg;
  logic [12:0]                    height_reg;
  logic [cdrb_pkg::KREG_BITS-1:0] kern_reg [cdrb_pkg::KMAX];
  logic [7:0]                     rows [SLOTS][MAX_WIDTH];
  int unsigned                    col_in, row_in, pos_out;
  cdrb_pkg::out_item_t            filtered_q [$];

  assign pending_count = filtered_q.size();

  function automatic int signed tap_weight(int j, int k);
    logic [COEF_BITS-1:0] f;
    f = kern_reg[j][k*cdrb_pkg::FIELD_STRIDE +: COEF_BITS];
    return int'($signed(f));
  endfunction

  // Filter the pixel at pos_out and advance the output position.
  function automatic cdrb_pkg::out_item_t filter_next(int unsigned w, int unsigned h);
    cdrb_pkg::out_item_t r;
    int unsigned         rr, cc;
    int                  x, y;
    longint              acc;
    rr  = pos_out / w;
    cc  = pos_out % w;
    acc = 0;
    if (rr >= h) rr = h - 1;
    for (int j = 0; j < WIN_SIZE; j++)
      for (int k = 0; k < WIN_SIZE; k++) begin
        x = int'(cc) + j - HALF;
        y = int'(rr) + k - HALF;
        if (x < 0) x = 0;
        if (x >= int'(w)) x = w - 1;
        if (y < 0) y = 0;
        if (y >= int'(h)) y = h - 1;
        acc += longint'(rows[y % SLOTS][x]) * tap_weight(j, k);
      end
    if (acc < 0) acc = 0;
    else begin
      acc = acc >>> cdrb_pkg::FRAC_BITS;
      if (acc > cdrb_pkg::PIXEL_MAX) acc = cdrb_pkg::PIXEL_MAX;
    end
    r.pixel_out = acc[7:0];
    if (longint'(pos_out) + 1 >= longint'(w) * h) begin
      r.frame_last = 1'b1;
      col_in = 0; row_in = 0; pos_out = 0;
    end else begin
      r.frame_last = 1'b0;
      pos_out++;
    end
    return r;
  endfunction

  task automatic accept_item(cdrb_pkg::in_item_t it);
    int unsigned w, h, c;
    longint      arrived;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 :
        (height_reg > cdrb_pkg::HEIGHT_LIMIT ? cdrb_pkg::HEIGHT_LIMIT : height_reg);
    if (!it.drain && row_in < h) begin
      c = col_in < MAX_WIDTH ? col_in : MAX_WIDTH - 1;
      rows[row_in % SLOTS][c] = it.pixel_in;
      col_in++;
      if (col_in >= w) begin
        col_in = 0;
        row_in++;
      end
      arrived = longint'(row_in) * w + col_in;
      if (arrived > longint'(pos_out) + HALF * w + HALF)
        filtered_q.push_back(filter_next(w, h));
    end else if (row_in >= h) begin
      filtered_q.push_back(filter_next(w, h));
    end
  endtask

  always @(posedge clk) begin
    cdrb_pkg::out_item_t want;
    if (!rst_n) begin
      width_reg  <= 12'd640;
      height_reg <= 13'd480;
      for (int i = 0; i < cdrb_pkg::KMAX; i++) kern_reg[i] <= '0;
      col_in = 0; row_in = 0; pos_out = 0;
      fail_count = 0;
      filtered_q.delete();
    end else begin
      // Predict before the register write of this edge lands.
      if (in_valid && in_ready) accept_item(in_data);
      if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result pixel=%0d last=%0d",
                     out_data.pixel_out, out_data.frame_last);
        end else begin
          want = filtered_q.pop_front();
          if (want !== out_data) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected pixel=%0d last=%0d, got pixel=%0d last=%0d",
                       want.pixel_out, want.frame_last,
                       out_data.pixel_out, out_data.frame_last);
          end
        end
      end
      if (cfg_we) begin
        case (cdrb_pkg::cfg_reg_e'(cfg_index))
          cdrb_pkg::CFG_IMAGE_WIDTH:  width_reg   <= cfg_wdata[11:0];
          cdrb_pkg::CFG_IMAGE_HEIGHT: height_reg  <= cfg_wdata[12:0];
          cdrb_pkg::CFG_KERNEL_A:     kern_reg[0] <= cfg_wdata;
          cdrb_pkg::CFG_KERNEL_B:     kern_reg[1] <= cfg_wdata;
          cdrb_pkg::CFG_KERNEL_C:     kern_reg[2] <= cfg_wdata;
          cdrb_pkg::CFG_KERNEL_D:     kern_reg[3] <= cfg_wdata;
          cdrb_pkg::CFG_KERNEL_E:     kern_reg[4] <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- sim/conv2d_replicate_border_core_tb.sv -----
// ----------------------------------------------------------------------------
// Testbench top for the replicated-border convolution core
// Programs frame sizes and kernels, streams whole frames plus flush items
// with bursty input and stalling output, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module conv2d_replicate_border_core_tb;

  localparam int CYCLE_LIMIT = 20000;
  localparam int WIN_SIZE_TB = 3;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  cdrb_pkg::in_item_t             in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  cdrb_pkg::out_item_t            out_data;
  logic                           cfg_we = 1'b0;
  logic [2:0]                     cfg_index = '0;
  logic [cdrb_pkg::KREG_BITS-1:0] cfg_wdata = '0;
  int                             fail_count, pending_count;
  int                             sent = 0;
  int                             idle_cycles = 0;
  bit                             hold_out = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  conv2d_replicate_border_core dut (.*);

  conv2d_replicate_border_core_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .pending_count
  );

  // Hold the write enable; the caller drops it after the last write.
  task automatic write_reg(cdrb_pkg::cfg_reg_e idx, logic [cdrb_pkg::KREG_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Send one item; burst gaps are random, with some stretches gap-free.
  task automatic send_item(logic [7:0] pix, logic drn, int gap_max);
    int gap;
    gap = (gap_max > 0 && $urandom_range(3) == 0) ? $urandom_range(gap_max) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{pixel_in: pix, drain: drn};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [cdrb_pkg::KREG_BITS-1:0] rand_kernel(int mode);
    logic [cdrb_pkg::KREG_BITS-1:0] v;
    v = cdrb_pkg::KREG_BITS'({$urandom, $urandom});
    case (mode)
      0: v = '0;
      1: v = '1;
      2: for (int k = 0; k < cdrb_pkg::KMAX; k++)
           v[k*cdrb_pkg::FIELD_STRIDE +: 12] = 12'h7FF;
      3: for (int k = 0; k < cdrb_pkg::KMAX; k++)
           v[k*cdrb_pkg::FIELD_STRIDE +: 12] = 12'h800;
      4: for (int k = 0; k < cdrb_pkg::KMAX; k++)
           v[k*cdrb_pkg::FIELD_STRIDE +: 12] = 12'($urandom_range(40)) - 12'd8;
      default: ;
    endcase
    return v;
  endfunction

  // One frame of pixels followed by exactly the flush items it needs.
  task automatic run_frame(int w, int h, int gap_max, int mode);
    int noise, n_flush;
    for (int i = 0; i < w * h; i++) begin
      noise = $urandom_range(19);
      if (mode == 1 && noise == 0) send_item(8'($urandom), 1'b1, gap_max);  // early drain
      case (mode)
        2: send_item((i % 2) ? 8'hFF : 8'h00, 1'b0, gap_max);
        default: send_item(8'($urandom), 1'b0, gap_max);
      endcase
    end
    n_flush = (WIN_SIZE_TB / 2) * w + (WIN_SIZE_TB / 2);
    if (n_flush > w * h) n_flush = w * h;
    // Flush pending outputs; a pixel here acts as a drain.
    for (int i = 0; i < n_flush; i++)
      send_item(8'($urandom), $urandom_range(3) != 0, gap_max);
  endtask

  task automatic set_frame(int w, int h, int kmode);
    write_reg(cdrb_pkg::CFG_IMAGE_WIDTH, cdrb_pkg::KREG_BITS'(w));
    write_reg(cdrb_pkg::CFG_IMAGE_HEIGHT, cdrb_pkg::KREG_BITS'(h));
    write_reg(cdrb_pkg::CFG_KERNEL_A, rand_kernel(kmode));
    write_reg(cdrb_pkg::CFG_KERNEL_B, rand_kernel(kmode));
    write_reg(cdrb_pkg::CFG_KERNEL_C, rand_kernel(kmode));
    write_reg(cdrb_pkg::CFG_KERNEL_D, rand_kernel($urandom_range(5)));
    write_reg(cdrb_pkg::CFG_KERNEL_E, rand_kernel($urandom_range(5)));
    cfg_we <= 1'b0;
  endtask

  // Receiver: own stall pattern, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_out) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(9) < 7) || sent < 60;
  end

  initial begin
    wait (rst_n);
    repeat (300) @(posedge clk);
    hold_out = 1'b1;
    repeat (400) @(posedge clk);
    hold_out = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= CYCLE_LIMIT) begin
      $display("conv2d_replicate_border_core_tb failed");
      $finish;
    end
  end

  initial begin
    int w, h;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: degenerate sizes, extreme pixels and coefficients.
    set_frame(1, 1, 1);
    run_frame(1, 1, 0, 0);
    wait_idle();
    set_frame(0, 0, 2);
    run_frame(1, 1, 0, 2);
    wait_idle();
    set_frame(4, 3, 2);
    run_frame(4, 3, 0, 2);
    wait_idle();
    set_frame(3, 2, 3);
    run_frame(3, 2, 2, 1);
    wait_idle();
    // Random frames, mostly small.
    while (sent < 1500) begin
      w = $urandom_range(12, 1);
      h = $urandom_range(9, 1);
      set_frame(w, h, $urandom_range(5));
      run_frame(w, h, $urandom_range(4), $urandom_range(3));
      wait_idle();
    end
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("conv2d_replicate_border_core_tb passed");
    else
      $display("conv2d_replicate_border_core_tb failed");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/cdrb_pkg.sv
hw/rtl/cdrb_front.sv
hw/rtl/cdrb_queue.sv
hw/rtl/cdrb_back.sv
hw/rtl/conv2d_replicate_border_core.sv
hw/rtl/cdrb_checker.sv
sim/conv2d_replicate_border_core_checker.sv
sim/conv2d_replicate_border_core_tb.sv
